// ===== src/dcfb_pkg.sv =====
// dcfb_pkg: shared types and constants for the host/DSP FIFO and latch bridge.
// Holds the transaction payload structs, controller command/status structs and codes.
// No dependencies.
`timescale 1ns / 1ps

package dcfb_pkg;

	localparam int DSP_DEPTH  = 32;
	localparam int DAC_DEPTH  = 16;
	localparam int DSP_PTR_W  = $clog2(DSP_DEPTH);
	localparam int DAC_PTR_W  = $clog2(DAC_DEPTH);
	localparam int DSP_FILL_W = $clog2(DSP_DEPTH + 1);
	localparam int DAC_FILL_W = $clog2(DAC_DEPTH + 1);

	localparam logic [2:0] MODE_HOST_RD = 3'd0;
	localparam logic [2:0] MODE_HOST_WR = 3'd1;
	localparam logic [2:0] MODE_DSP_RD  = 3'd2;
	localparam logic [2:0] MODE_DSP_WR  = 3'd3;
	localparam logic [2:0] MODE_TICK    = 3'd4;
	localparam logic [2:0] MODE_UART    = 3'd5;

	localparam logic [2:0] OFF_FLAGS = 3'd0;
	localparam logic [2:0] OFF_FIFO  = 3'd2;
	localparam logic [2:0] OFF_TLC   = 3'd4;
	localparam logic [2:0] OFF_ZERO  = 3'd6;

	localparam logic [2:0] PORT_SEM  = 3'd0;
	localparam logic [2:0] PORT_FIFO = 3'd1;

	localparam logic [6:0] VOLUME_FULL = 7'd100;

	typedef struct packed {
		logic [2:0]  mode;
		logic [2:0]  reg_offset;
		logic [2:0]  dsp_port;
		logic [15:0] write_data;
		logic        line_level;
	} item_t;

	typedef struct packed {
		logic [15:0]           read_data;
		logic signed [15:0]    dac_sample;
		logic                  dsp_reset_line;
		logic                  dsp_int_assert;
		logic                  dsp_bio_flag;
		logic [2:0]            host_irq_level;
		logic [DSP_FILL_W-1:0] to_dsp_count;
		logic [DAC_FILL_W-1:0] to_dac_count;
		logic [15:0]           underrun_total;
	} result_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic mul;
		logic div;
		logic fix;
	} cmd_t;

	typedef struct packed {
		logic tick;
	} stat_t;

endpackage

// ===== src/dcfb_ctrl.sv =====
// dcfb_ctrl: transaction sequencer for the bridge.
// Issues load/exec/scale commands to dcfb_dp and raises the result strobe.
// Depends on dcfb_pkg.
`timescale 1ns / 1ps

module dcfb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	output dcfb_pkg::cmd_t   cmd,
	input  dcfb_pkg::stat_t  stat
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIX  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_EXEC;
			ST_EXEC: begin
				if (stat.tick) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MUL:  state_d = ST_DIV;
			ST_DIV:  state_d = ST_FIX;
			ST_FIX:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == ST_EXEC) && !stat.tick) || (state_q == ST_FIX);
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign cmd.load = (state_q == ST_IDLE) && start;
	assign cmd.exec = (state_q == ST_EXEC);
	assign cmd.mul  = (state_q == ST_MUL);
	assign cmd.div  = (state_q == ST_DIV);
	assign cmd.fix  = (state_q == ST_FIX);

endmodule

// ===== src/dcfb_dp.sv =====
// dcfb_dp: bridge datapath: both word FIFOs, latches, interrupt encoder and DAC scaler.
// Driven by dcfb_ctrl commands; holds the volume register.
// Depends on dcfb_pkg.
`timescale 1ns / 1ps

module dcfb_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  dcfb_pkg::cmd_t      cmd,
	output dcfb_pkg::stat_t     stat,
	input  dcfb_pkg::item_t     item,
	input  logic                cfg_we,
	input  logic [6:0]          cfg_data,
	output dcfb_pkg::result_t   result
);

	localparam int DSP_PW = dcfb_pkg::DSP_PTR_W;
	localparam int DAC_PW = dcfb_pkg::DAC_PTR_W;
	localparam int DSP_FW = dcfb_pkg::DSP_FILL_W;
	localparam int DAC_FW = dcfb_pkg::DAC_FILL_W;

	localparam logic [15:0] SAMPLE_MASK = 16'hFFF0;
	localparam logic [15:0] SPC_MASK    = 16'h0041;
	localparam logic [15:0] TLC_MASK    = 16'h4140;
	localparam logic [15:0] ALL_ONES    = 16'hFFFF;
	localparam logic signed [15:0] QUIET = 16'sd120;
	localparam logic [15:0] RECIP       = 16'd41943; // 2^20 / 25, rounded down
	localparam int          RECIP_SH    = 20;
	localparam logic [21:0] DIV_LOW     = 22'd25;

	dcfb_pkg::item_t item_q;
	logic [6:0]      volume_q;

	logic [15:0]             dsp_mem_q [dcfb_pkg::DSP_DEPTH];
	logic [dcfb_pkg::DSP_DEPTH-1:0] dsp_vld_q;
	logic [DSP_PW-1:0]       dsp_head_q, dsp_tail_q;
	logic [DSP_FW-1:0]       dsp_fill_q;
	logic [15:0]             dac_mem_q [dcfb_pkg::DAC_DEPTH];
	logic [dcfb_pkg::DAC_DEPTH-1:0] dac_vld_q;
	logic [DAC_PW-1:0]       dac_head_q, dac_tail_q;
	logic [DAC_FW-1:0]       dac_fill_q;

	logic        sem_q, err_q, held_q;
	logic [6:0]  spc_q;
	logic [14:0] tlc_q;
	logic [2:0]  irq_q;
	logic [15:0] under_q;

	logic [15:0] dsp_mem_s1, dac_mem_s1;
	logic        dsp_vld_s1, dac_vld_s1;

	logic [15:0] rd_q;
	logic        intr_q;
	logic signed [15:0] sample_q;

	logic signed [15:0] s_s1, s_s2, s_s3;
	logic signed [23:0] prod_s2;
	logic               byp_s2, byp_s3, neg_s3;
	logic [19:0]        x_s3;
	logic [15:0]        est_s3;

	// exec-stage next values
	logic [15:0] dsp_word, dac_word, rd_d;
	logic signed [15:0] s_d;
	logic        intr_d, sem_d, err_d, held_d, clr_d;
	logic        dsp_push, dsp_pop, dac_push, dac_pop, under_inc;
	logic [6:0]  spc_d;
	logic [14:0] tlc_d;
	logic [2:0]  irq_d;
	logic [DAC_FW-1:0] dac_fill_after;

	assign dsp_word = dsp_vld_s1 ? dsp_mem_s1 : 16'h0000;
	assign dac_word = dac_vld_s1 ? dac_mem_s1 : 16'h0000;
	assign s_d      = $signed(dac_word & SAMPLE_MASK);
	assign stat.tick = (item_q.mode == dcfb_pkg::MODE_TICK);

	always_comb begin
		rd_d      = 16'h0000;
		intr_d    = 1'b0;
		sem_d     = sem_q;
		err_d     = err_q;
		held_d    = held_q;
		clr_d     = 1'b0;
		spc_d     = spc_q;
		tlc_d     = tlc_q;
		irq_d     = irq_q;
		dsp_push  = 1'b0;
		dsp_pop   = 1'b0;
		dac_push  = 1'b0;
		dac_pop   = 1'b0;
		under_inc = 1'b0;
		dac_fill_after = dac_fill_q;
		unique case (item_q.mode)
			dcfb_pkg::MODE_HOST_RD: begin
				if (item_q.reg_offset == dcfb_pkg::OFF_FLAGS) begin
					rd_d = {9'h000, spc_q} | {8'h00, sem_q, 7'h00} | {10'h000, err_q, 5'h00};
				end else if (item_q.reg_offset == dcfb_pkg::OFF_TLC) begin
					rd_d = {1'b0, tlc_q};
				end else if (item_q.reg_offset == dcfb_pkg::OFF_ZERO) begin
					rd_d = 16'h0000;
				end else begin
					rd_d = ALL_ONES;
				end
			end
			dcfb_pkg::MODE_HOST_WR: begin
				if (item_q.reg_offset == dcfb_pkg::OFF_FLAGS) begin
					spc_d  = 7'(item_q.write_data & SPC_MASK);
					clr_d  = item_q.write_data[0];
					intr_d = item_q.write_data[0];
					held_d = item_q.write_data[0];
					if (item_q.write_data[0] || item_q.write_data[1]) begin
						sem_d = 1'b0;
						err_d = 1'b0;
					end
					irq_d[1] = item_q.write_data[6] &&
						(sem_d || (!(item_q.write_data[0] || item_q.write_data[1]) && irq_q[1]));
				end else if (item_q.reg_offset == dcfb_pkg::OFF_FIFO) begin
					dsp_push = (dsp_fill_q < DSP_FW'(dcfb_pkg::DSP_DEPTH));
				end else if (item_q.reg_offset == dcfb_pkg::OFF_TLC) begin
					tlc_d    = 15'(item_q.write_data & TLC_MASK);
					irq_d[0] = 1'b0;
				end
			end
			dcfb_pkg::MODE_DSP_RD: begin
				if (item_q.dsp_port == dcfb_pkg::PORT_FIFO) begin
					rd_d    = dsp_word;
					dsp_pop = (dsp_fill_q != '0);
				end else begin
					rd_d = ALL_ONES;
				end
			end
			dcfb_pkg::MODE_DSP_WR: begin
				if (item_q.dsp_port == dcfb_pkg::PORT_SEM) begin
					sem_d    = 1'b1;
					err_d    = item_q.write_data[0];
					irq_d[1] = spc_q[6];
				end else if (item_q.dsp_port == dcfb_pkg::PORT_FIFO) begin
					dac_push = (dac_fill_q < DAC_FW'(dcfb_pkg::DAC_DEPTH));
				end
			end
			dcfb_pkg::MODE_TICK: begin
				under_inc = (dac_fill_q == '0) && !held_q && (s_d > QUIET || s_d < -QUIET) &&
					(under_q != ALL_ONES);
				dac_pop = (dac_fill_q != '0);
				if (dac_pop) begin
					dac_fill_after = dac_fill_q - 1'b1;
				end
				intr_d = (dac_fill_after < DAC_FW'(dcfb_pkg::DAC_DEPTH));
			end
			dcfb_pkg::MODE_UART: begin
				irq_d[2] = item_q.line_level;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q   <= dcfb_pkg::VOLUME_FULL;
			dsp_vld_q  <= '0;
			dsp_head_q <= '0;
			dsp_tail_q <= '0;
			dsp_fill_q <= '0;
			dac_vld_q  <= '0;
			dac_head_q <= '0;
			dac_tail_q <= '0;
			dac_fill_q <= '0;
			sem_q      <= 1'b0;
			err_q      <= 1'b0;
			held_q     <= 1'b1;
			spc_q      <= '0;
			tlc_q      <= '0;
			irq_q      <= '0;
			under_q    <= '0;
		end else begin
			if (cfg_we) begin
				volume_q <= cfg_data;
			end
			if (cmd.exec) begin
				sem_q  <= sem_d;
				err_q  <= err_d;
				held_q <= held_d;
				spc_q  <= spc_d;
				tlc_q  <= tlc_d;
				irq_q  <= irq_d;
				if (under_inc) begin
					under_q <= under_q + 1'b1;
				end
				if (clr_d) begin
					dsp_vld_q  <= '0;
					dsp_head_q <= '0;
					dsp_tail_q <= '0;
					dsp_fill_q <= '0;
					dac_vld_q  <= '0;
					dac_head_q <= '0;
					dac_tail_q <= '0;
					dac_fill_q <= '0;
				end else begin
					if (dsp_push) begin
						dsp_vld_q[dsp_head_q] <= 1'b1;
						dsp_head_q <= (dsp_head_q == DSP_PW'(dcfb_pkg::DSP_DEPTH - 1)) ?
							'0 : dsp_head_q + 1'b1;
						dsp_fill_q <= dsp_fill_q + 1'b1;
					end
					if (dsp_pop) begin
						dsp_tail_q <= (dsp_tail_q == DSP_PW'(dcfb_pkg::DSP_DEPTH - 1)) ?
							'0 : dsp_tail_q + 1'b1;
						dsp_fill_q <= dsp_fill_q - 1'b1;
					end
					if (dac_push) begin
						dac_vld_q[dac_head_q] <= 1'b1;
						dac_head_q <= (dac_head_q == DAC_PW'(dcfb_pkg::DAC_DEPTH - 1)) ?
							'0 : dac_head_q + 1'b1;
						dac_fill_q <= dac_fill_q + 1'b1;
					end
					if (dac_pop) begin
						dac_tail_q <= (dac_tail_q == DAC_PW'(dcfb_pkg::DAC_DEPTH - 1)) ?
							'0 : dac_tail_q + 1'b1;
						dac_fill_q <= dac_fill_after;
					end
				end
			end
		end
	end

	// FIFO stores: one write and one registered tail read each
	always_ff @(posedge clk) begin
		if (cmd.exec && dsp_push && !clr_d) begin
			dsp_mem_q[dsp_head_q] <= item_q.write_data;
		end
		if (cmd.exec && dac_push && !clr_d) begin
			dac_mem_q[dac_head_q] <= item_q.write_data;
		end
		dsp_mem_s1 <= dsp_mem_q[dsp_tail_q];
		dac_mem_s1 <= dac_mem_q[dac_tail_q];
		dsp_vld_s1 <= dsp_vld_q[dsp_tail_q];
		dac_vld_s1 <= dac_vld_q[dac_tail_q];
	end

	// transaction capture, result registers and the volume scaler
	logic [23:0] mag;
	logic [35:0] est_full;
	logic [21:0] rem;
	logic [15:0] quot;

	assign mag      = prod_s2[23] ? 24'(-prod_s2) : 24'(prod_s2);
	assign est_full = 36'(mag[21:2]) * 36'(RECIP);
	assign rem      = 22'(x_s3) - (22'(est_s3) * DIV_LOW);
	assign quot     = est_s3 + 16'(rem >= DIV_LOW);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.exec) begin
			rd_q     <= rd_d;
			intr_q   <= intr_d;
			sample_q <= '0;
			s_s1     <= s_d;
		end
		if (cmd.mul) begin
			prod_s2 <= s_s1 * $signed({1'b0, volume_q});
			byp_s2  <= (volume_q >= dcfb_pkg::VOLUME_FULL);
			s_s2    <= s_s1;
		end
		if (cmd.div) begin
			x_s3   <= mag[21:2];
			est_s3 <= est_full[RECIP_SH +: 16];
			neg_s3 <= prod_s2[23];
			byp_s3 <= byp_s2;
			s_s3   <= s_s2;
		end
		if (cmd.fix) begin
			sample_q <= byp_s3 ? s_s3 : (neg_s3 ? -$signed(quot) : $signed(quot));
		end
	end

	assign result.read_data      = rd_q;
	assign result.dac_sample     = sample_q;
	assign result.dsp_reset_line = held_q;
	assign result.dsp_int_assert = intr_q;
	assign result.dsp_bio_flag   = sem_q;
	assign result.host_irq_level = irq_q[2] ? 3'd6 : (irq_q[1] ? 3'd5 : (irq_q[0] ? 3'd4 : 3'd0));
	assign result.to_dsp_count   = dsp_fill_q;
	assign result.to_dac_count   = dac_fill_q;
	assign result.underrun_total = under_q;

endmodule

// ===== src/dual_cpu_fifo_latch_bridge_top.sv =====
// Host-to-DSP and DSP-to-DAC FIFO bridge with semaphore, flag latches and irq encoder.
// Top level: instantiates dcfb_ctrl and dcfb_dp.
// Depends on dcfb_pkg, dcfb_ctrl, dcfb_dp.
//
// Usage:
//   Input: drive item and raise start; the transaction is taken at an edge with start
//   high and busy low. One transaction at a time.
//   Output: done is high for exactly one cycle while result holds the answer; the
//   receiver must take it then. Status fields reflect state after the transaction.
//   Config: cfg_we writes cfg_data into the volume register at the next edge; write
//   only while no transaction is in flight.
//   Sequence: after the accepting edge, done rises once the tail read and update states
//   have run, or for a tick once tail read, update, multiply, reciprocal multiply and
//   correction have run; the result is taken at the edge that ends the done cycle.
//   busy drops in the done cycle, so a new transaction can be taken there.
//   Reset: arst_n clears both FIFOs and all latches, holds the DSP in reset and sets
//   volume to 100; the block is ready on the first edge after release.
`timescale 1ns / 1ps

module dual_cpu_fifo_latch_bridge_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  dcfb_pkg::item_t    item,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_data,
	output logic               done,
	output dcfb_pkg::result_t  result
);

	dcfb_pkg::cmd_t  cmd;
	dcfb_pkg::stat_t stat;

	dcfb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	dcfb_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.result   (result)
	);

endmodule
